// ===== hw/rtl/pbp_pkg.sv =====
// ----------------------------------------------------------------------------
// pbp_pkg - perceptron branch predictor package
// Field widths, weight limits and reset values shared by the interfaces
// and the predictor.
// ----------------------------------------------------------------------------
package pbp_pkg;

   // item field widths
   localparam int PC_W     = 32;
   localparam int SUM_W    = 12;
   localparam int THR_W    = 11;

   // weights and history
   localparam int WEIGHT_W    = 8;
   localparam int HIST_W      = 15;
   localparam int WEIGHTS_MAX = 16;   // adder tree width, widest legal row

   // parameter defaults
   localparam int TABLE_ROWS_DEF      = 256;
   localparam int WEIGHTS_PER_ROW_DEF = 16;

   // reset value of the training threshold
   localparam logic [THR_W-1:0] THR_RESET = 11'd56;

   typedef logic signed [WEIGHT_W-1:0] weight_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

   localparam weight_type WEIGHT_MAX = 8'sh7f;
   localparam weight_type WEIGHT_MIN = 8'sh80;

endpackage

// ===== hw/rtl/pbp_req_if.sv =====
// ----------------------------------------------------------------------------
// pbp_req_if - resolved branch channel
// Valid/ready channel carrying one resolved branch per item.
// ----------------------------------------------------------------------------
interface pbp_req_if;
   logic                      valid;
   logic                      ready;
   logic [pbp_pkg::PC_W-1:0]  branch_pc;
   logic                      taken;

   modport source (output valid, output branch_pc, output taken, input ready);
   modport sink   (input valid, input branch_pc, input taken, output ready);
endinterface

// ===== hw/rtl/pbp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pbp_rsp_if - prediction result channel
// Valid/ready channel carrying the prediction and the perceptron sum.
// ----------------------------------------------------------------------------
interface pbp_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 predict_taken;
   pbp_pkg::sum_type     perceptron_sum;

   modport source (output valid, output predict_taken, output perceptron_sum,
                   input ready);
   modport sink   (input valid, input predict_taken, input perceptron_sum,
                   output ready);
endinterface

// ===== hw/rtl/perceptron_branch_predictor.sv =====
// Pipeline: an accepted item moves through v0, v1, v2, v3 to the out_v result.
// Throughput: one item per cycle unless rsp ready stalls; the compute-stage row
//   read-modify-write sets the rate, bypassed for back-to-back same-row items.
// Reset: synchronous, active high. After reset a clearing pass zeroes the
//   weight table, one row per cycle through every row, with req ready low.
// ----------------------------------------------------------------------------
// perceptron_branch_predictor - global history perceptron predictor
// Row index by pc modulo the table size (reciprocal multiply), registered
// weight row read, signed adder tree, saturating training, history shift.
// ----------------------------------------------------------------------------
module perceptron_branch_predictor #(
   parameter int TABLE_ROWS      = pbp_pkg::TABLE_ROWS_DEF,
   parameter int WEIGHTS_PER_ROW = pbp_pkg::WEIGHTS_PER_ROW_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   pbp_req_if.sink                   req_ch,
   pbp_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [pbp_pkg::THR_W-1:0] csr_wdata
);
   import pbp_pkg::*;

   localparam int ROW_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
   // floor(2^32 / TABLE_ROWS); quotient estimate is low by at most one
   localparam logic [PC_W-1:0] RECIP = PC_W'((64'd1 << PC_W) / 64'(TABLE_ROWS));
   localparam logic [PC_W-1:0] ROWS_PC = PC_W'(TABLE_ROWS);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TABLE_ROWS - 1);

   typedef weight_type [WEIGHTS_PER_ROW-1:0] row_type;

   // ---------------------------------------------------------------- state
   logic               clear_ff, clear_in;
   logic [ROW_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [HIST_W-1:0]  hist_ff, hist_in;

   logic               v0_ff, v1_ff, v2_ff, v3_ff, out_v_ff;
   logic [PC_W-1:0]    pc0_ff, pc1_ff;
   logic [PC_W-1:0]    q1_ff;
   logic               tk0_ff, tk1_ff, tk2_ff, tk3_ff;
   logic [ROW_W-1:0]   row2_ff, row3_ff;
   row_type            rd_data_ff;
   row_type            wr_data_ff;
   logic               bypass_ff;
   logic               pred_ff;
   sum_type            sum_ff;

   row_type            mem [TABLE_ROWS];

   // --------------------------------------------------------- stage enables
   logic en_out, en3, en2, en1, en0, item_wr;

   assign en_out  = !out_v_ff || rsp_ch.ready;
   assign en3     = !v3_ff || en_out;
   assign en2     = !v2_ff || en3;
   assign en1     = !v1_ff || en2;
   assign en0     = !v0_ff || en1;
   assign item_wr = v3_ff && en_out;

   assign req_ch.ready = en0 && !clear_ff;

   // ------------------------------------------------------ row index math
   logic [2*PC_W-1:0] prod;
   logic [PC_W-1:0]   q0;
   logic [PC_W-1:0]   rem;
   logic [ROW_W-1:0]  row1;

   always_comb begin
      prod = 64'(pc0_ff) * 64'(RECIP);
      q0   = prod[2*PC_W-1:PC_W];
   end

   always_comb begin
      rem = pc1_ff - PC_W'(q1_ff * ROWS_PC);
      if (rem >= ROWS_PC) begin
         rem = rem - ROWS_PC;
      end
      row1 = rem[ROW_W-1:0];
   end

   // -------------------------------------------- compute: sum and training
   row_type row_data;
   sum_type term [WEIGHTS_MAX];
   sum_type lvl1 [WEIGHTS_MAX/2];
   sum_type lvl2 [WEIGHTS_MAX/4];
   sum_type lvl3 [WEIGHTS_MAX/8];
   sum_type sum;
   logic [SUM_W-1:0] mag;
   logic    pred;
   logic    train;
   row_type new_row;

   assign row_data = bypass_ff ? wr_data_ff : rd_data_ff;

   // signed terms: bias, then +w or -w by history bit h-1
   always_comb begin
      for (int h = 0; h < WEIGHTS_MAX; h++) begin
         term[h] = '0;
      end
      term[0] = SUM_W'(row_data[0]);
      for (int h = 1; h < WEIGHTS_PER_ROW; h++) begin
         if (hist_ff[h-1]) begin
            term[h] = SUM_W'(row_data[h]);
         end else begin
            term[h] = -SUM_W'(row_data[h]);
         end
      end
   end

   // balanced adder tree
   always_comb begin
      for (int i = 0; i < WEIGHTS_MAX/2; i++) begin
         lvl1[i] = term[2*i] + term[2*i+1];
      end
      for (int i = 0; i < WEIGHTS_MAX/4; i++) begin
         lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
      end
      for (int i = 0; i < WEIGHTS_MAX/8; i++) begin
         lvl3[i] = lvl2[2*i] + lvl2[2*i+1];
      end
      sum = lvl3[0] + lvl3[1];
   end

   // prediction and training decision
   always_comb begin
      pred  = !sum[SUM_W-1];
      mag   = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      train = (pred != tk3_ff) || (mag <= SUM_W'(thr_ff));
   end

   // saturating weight steps
   always_comb begin
      logic up;
      up      = 1'b0;
      new_row = row_data;
      if (train) begin
         for (int h = 0; h < WEIGHTS_PER_ROW; h++) begin
            up = (h == 0) ? tk3_ff : (tk3_ff == hist_ff[(h == 0) ? 0 : h-1]);
            if (up) begin
               if (row_data[h] != WEIGHT_MAX) begin
                  new_row[h] = row_data[h] + 8'sd1;
               end
            end else begin
               if (row_data[h] != WEIGHT_MIN) begin
                  new_row[h] = row_data[h] - 8'sd1;
               end
            end
         end
      end
   end

   // ------------------------------------------------ control next values
   always_comb begin
      clear_in   = clear_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clear_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST_ROW) begin
            clear_in = 1'b0;
         end
      end
      thr_in  = csr_we ? csr_wdata : thr_ff;
      hist_in = item_wr ? {hist_ff[HIST_W-2:0], tk3_ff} : hist_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff   <= 1'b1;
         clr_cnt_ff <= '0;
         thr_ff     <= THR_RESET;
         hist_ff    <= '0;
         v0_ff      <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         out_v_ff   <= 1'b0;
         bypass_ff  <= 1'b0;
      end else begin
         clear_ff   <= clear_in;
         clr_cnt_ff <= clr_cnt_in;
         thr_ff     <= thr_in;
         hist_ff    <= hist_in;
         if (en0) v0_ff <= req_ch.valid && req_ch.ready;
         if (en1) v1_ff <= v0_ff;
         if (en2) v2_ff <= v1_ff;
         if (en3) begin
            v3_ff     <= v2_ff;
            // row written at this edge is the one being read: take the bypass
            bypass_ff <= item_wr && (row3_ff == row2_ff);
         end
         if (en_out) out_v_ff <= v3_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en0) begin
         pc0_ff <= req_ch.branch_pc;
         tk0_ff <= req_ch.taken;
      end
      if (en1) begin
         pc1_ff <= pc0_ff;
         q1_ff  <= q0;
         tk1_ff <= tk0_ff;
      end
      if (en2) begin
         row2_ff <= row1;
         tk2_ff  <= tk1_ff;
      end
      if (en3) begin
         row3_ff <= row2_ff;
         tk3_ff  <= tk2_ff;
      end
      if (item_wr) begin
         wr_data_ff <= new_row;
      end
      if (en_out) begin
         pred_ff <= pred;
         sum_ff  <= sum;
      end
   end

   // weight table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (item_wr) begin
         mem[row3_ff] <= new_row;
      end
      if (en3) begin
         rd_data_ff <= mem[row2_ff];
      end
   end

   assign rsp_ch.valid          = out_v_ff;
   assign rsp_ch.predict_taken  = pred_ff;
   assign rsp_ch.perceptron_sum = sum_ff;

   // ------------------------------------------------------------ checks
   a_no_accept_in_clear : assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !(req_ch.valid && req_ch.ready))
      else $error("item accepted during table clear");

   a_pipe_empty_in_clear : assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !(v0_ff || v1_ff || v2_ff || v3_ff))
      else $error("pipeline busy while clear owns the write port");

   a_hist_shift : assert property (@(posedge clock) disable iff (reset)
      item_wr |=> hist_ff[0] == $past(tk3_ff))
      else $error("history did not take the outcome of the written item");

   a_pred_matches_sum : assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (pred_ff == !sum_ff[SUM_W-1]))
      else $error("prediction disagrees with sum sign");

endmodule
